/* sv/raster_hole_fill_idw_unit_defines.svh */
// Assertion macros shared by the hole-fill block.
`ifndef RASTER_HOLE_FILL_IDW_UNIT_DEFINES_SVH
`define RASTER_HOLE_FILL_IDW_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define RHF_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// implication checked in the cycle after the antecedent
`define RHF_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

/* sv/rhf_pkg.sv */
// Shared types, constants and weight table of the hole-fill block.
`default_nettype none
package rhf_pkg;
  localparam int MAX_ROWS  = 256;
  localparam int MAX_COLS  = 256;
  localparam int MAX_REACH = 15;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int DIM_W     = $clog2(MAX_ROWS + 1) > $clog2(MAX_COLS + 1) ?
                             $clog2(MAX_ROWS + 1) : $clog2(MAX_COLS + 1);
  localparam int REACH_W   = $clog2(MAX_REACH + 1);
  localparam int HGT_W     = 20;
  localparam int CELL_W    = HGT_W + 1;
  localparam int WGT_W     = 17;
  localparam int NUM_W     = 44;
  localparam int DEN_W     = 21;
  localparam int PADDR_W   = 5;

  localparam logic [2:0] REG_NEED = 3'd0;
  localparam logic [2:0] REG_CRCH = 3'd1;
  localparam logic [2:0] REG_DRCH = 3'd2;
  localparam logic [2:0] REG_ROWS = 3'd3;
  localparam logic [2:0] REG_COLS = 3'd4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                     operation;
    logic [7:0]               row;
    logic [7:0]               col;
    logic signed [HGT_W-1:0]  height;
    logic                     height_valid;
  } in_item_t;

  typedef struct packed {
    logic signed [HGT_W-1:0]  out_height;
    logic                     out_valid;
    logic                     was_filled;
  } out_item_t;

  typedef struct packed {
    logic [3:0]          need;
    logic [REACH_W-1:0]  reach_c;
    logic [REACH_W-1:0]  reach_d;
    logic [DIM_W-1:0]    rows;
    logic [DIM_W-1:0]    cols;
  } cfg_t;

  // Q16 weights: round(65536/d) straight, round(46341/d) diagonal
  function automatic logic [WGT_W-1:0] weight(input logic diag, input logic [REACH_W-1:0] d);
    logic [WGT_W-1:0] w;
    unique case (d)
      4'd1:    w = diag ? 17'd46341 : 17'd65536;
      4'd2:    w = diag ? 17'd23171 : 17'd32768;
      4'd3:    w = diag ? 17'd15447 : 17'd21845;
      4'd4:    w = diag ? 17'd11585 : 17'd16384;
      4'd5:    w = diag ? 17'd9268  : 17'd13107;
      4'd6:    w = diag ? 17'd7724  : 17'd10923;
      4'd7:    w = diag ? 17'd6620  : 17'd9362;
      4'd8:    w = diag ? 17'd5793  : 17'd8192;
      4'd9:    w = diag ? 17'd5149  : 17'd7282;
      4'd10:   w = diag ? 17'd4634  : 17'd6554;
      4'd11:   w = diag ? 17'd4213  : 17'd5958;
      4'd12:   w = diag ? 17'd3862  : 17'd5461;
      4'd13:   w = diag ? 17'd3565  : 17'd5041;
      4'd14:   w = diag ? 17'd3310  : 17'd4681;
      4'd15:   w = diag ? 17'd3089  : 17'd4369;
      default: w = '0;
    endcase
    return w;
  endfunction
endpackage
`default_nettype wire

/* sv/raster_hole_fill_idw_unit.sv */
// Top level of the raster hole-fill block: register port and walker.
// A load in range writes the cell store directly. A query of a valid or
// out-of-range cell answers without a walk; a hole walks each direction one
// store read at a time, up to its reach, then runs the 44-step serial divider
// and output. Results appear on out_strobe for one cycle and cannot be held:
// the receiver cannot stall.
`default_nettype none
module raster_hole_fill_idw_unit (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  output logic                           busy,
  input  rhf_pkg::in_item_t              in_item,
  output logic                           out_strobe,
  output rhf_pkg::out_item_t             out_item,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [rhf_pkg::PADDR_W-1:0]     paddr,
  input  wire [31:0]                     pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  logic [3:0] need_r, crch_r, drch_r;
  logic [8:0] rows_r, cols_r;
  rhf_pkg::cfg_t cfg;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r <= 4'd8; crch_r <= 4'd3; drch_r <= 4'd2;
      rows_r <= 9'd256; cols_r <= 9'd256;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        rhf_pkg::REG_NEED: need_r <= pwdata[3:0];
        rhf_pkg::REG_CRCH: crch_r <= pwdata[3:0];
        rhf_pkg::REG_DRCH: drch_r <= pwdata[3:0];
        rhf_pkg::REG_ROWS: rows_r <= pwdata[8:0];
        rhf_pkg::REG_COLS: cols_r <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rhf_pkg::REG_NEED: prdata = {28'd0, need_r};
      rhf_pkg::REG_CRCH: prdata = {28'd0, crch_r};
      rhf_pkg::REG_DRCH: prdata = {28'd0, drch_r};
      rhf_pkg::REG_ROWS: prdata = {23'd0, rows_r};
      rhf_pkg::REG_COLS: prdata = {23'd0, cols_r};
      default: prdata = '0;
    endcase
    cfg.need    = need_r;
    cfg.reach_c = crch_r;
    cfg.reach_d = drch_r;
    cfg.rows    = rows_r == 9'd0 ? 9'd1 : (rows_r > 9'd256 ? 9'd256 : rows_r);
    cfg.cols    = cols_r == 9'd0 ? 9'd1 : (cols_r > 9'd256 ? 9'd256 : cols_r);
  end

  rhf_walker u_walk (
    .clk(clk), .rst_n(rst_n), .start(start), .item(in_item), .cfg(cfg),
    .busy(busy), .out_strobe(out_strobe), .out_item(out_item)
  );
endmodule
`default_nettype wire

/* sv/rhf_divider.sv */
// Restoring divider for the weighted mean, one quotient bit per cycle.
`default_nettype none
module rhf_divider (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [rhf_pkg::NUM_W-1:0]     num,
  input  wire [rhf_pkg::DEN_W-1:0]     den,
  output logic                         done,
  output logic [rhf_pkg::NUM_W-1:0]    quo
);
  localparam int CNT_W = $clog2(rhf_pkg::NUM_W + 1);
  logic                      busy_r, busy_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [rhf_pkg::NUM_W-1:0] q_r, q_nxt;
  logic [rhf_pkg::DEN_W-1:0] rem_r, rem_nxt;
  logic [rhf_pkg::DEN_W-1:0] den_r;
  logic [rhf_pkg::DEN_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, q_r[rhf_pkg::NUM_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(rhf_pkg::NUM_W);
      q_nxt    = num;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = rhf_pkg::DEN_W'(trial - {1'b0, den_r});
        q_nxt   = {q_r[rhf_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[rhf_pkg::DEN_W-1:0];
        q_nxt   = {q_r[rhf_pkg::NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done   <= busy_r && !busy_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end
  assign quo = q_r;
endmodule
`default_nettype wire

/* sv/rhf_walker.sv */
// Cell store and the sequencer that loads cells and walks the eight directions.
`default_nettype none
`include "raster_hole_fill_idw_unit_defines.svh"
module rhf_walker (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  rhf_pkg::in_item_t   item,
  input  rhf_pkg::cfg_t       cfg,
  output logic                busy,
  output logic                out_strobe,
  output rhf_pkg::out_item_t  out_item
);
  typedef enum logic [2:0] {S_IDLE, S_CENTER, S_STEP, S_WAIT, S_ACC, S_DIV, S_DONE} state_t;

  logic [rhf_pkg::CELL_W-1:0] mem [0:rhf_pkg::MAX_ROWS*rhf_pkg::MAX_COLS-1];
  logic [rhf_pkg::CELL_W-1:0] rdata_r;
  logic                       rd_en;
  logic [rhf_pkg::ADDR_W-1:0] rd_addr;

  state_t                     state_r;
  logic [rhf_pkg::ROW_W-1:0]  row_r;
  logic [rhf_pkg::COL_W-1:0]  col_r;
  logic [2:0]                 dir_r;
  logic [rhf_pkg::REACH_W-1:0] d_r;
  logic [3:0]                 miss_r;
  logic signed [rhf_pkg::NUM_W-1:0] num_r;
  logic [rhf_pkg::DEN_W-1:0]  den_r;
  logic signed [rhf_pkg::HGT_W-1:0] hit_h_r;
  logic [rhf_pkg::WGT_W-1:0]  hit_w_r;
  logic signed [rhf_pkg::WGT_W+rhf_pkg::HGT_W:0] prod;
  logic                       div_start;
  logic                       div_done;
  logic [rhf_pkg::NUM_W-1:0]  div_quo;
  logic [rhf_pkg::NUM_W-1:0]  mag;
  logic                       neg_r;
  logic                       in_div;
  logic                       div_next_ok;

  // step position along the current direction
  logic                       diag;
  logic [rhf_pkg::REACH_W-1:0] reach;
  logic signed [rhf_pkg::ROW_W+1:0] pr;
  logic signed [rhf_pkg::COL_W+1:0] pc;
  logic                       off_edge;
  logic                       in_range;
  logic [3:0]                 need;

  function automatic logic div_start_chk();
    return miss_r <= 4'd8 - need && den_r != '0;
  endfunction

  always_comb begin
    diag  = dir_r[2];
    reach = diag ? cfg.reach_d : cfg.reach_c;
    pr = $signed({2'b00, row_r});
    pc = $signed({2'b00, col_r});
    unique case (dir_r)
      3'd0: pc = pc + $signed({2'b00, d_r});
      3'd1: pc = pc - $signed({2'b00, d_r});
      3'd2: pr = pr + $signed({2'b00, d_r});
      3'd3: pr = pr - $signed({2'b00, d_r});
      3'd4: begin pr = pr + $signed({2'b00, d_r}); pc = pc + $signed({2'b00, d_r}); end
      3'd5: begin pr = pr + $signed({2'b00, d_r}); pc = pc - $signed({2'b00, d_r}); end
      3'd6: begin pr = pr - $signed({2'b00, d_r}); pc = pc + $signed({2'b00, d_r}); end
      default: begin pr = pr - $signed({2'b00, d_r}); pc = pc - $signed({2'b00, d_r}); end
    endcase
    off_edge = pr < 0 || pc < 0 || pr >= $signed((rhf_pkg::ROW_W+2)'(cfg.rows)) ||
               pc >= $signed((rhf_pkg::COL_W+2)'(cfg.cols));
    in_range = item.row < 8'(cfg.rows) || cfg.rows > rhf_pkg::DIM_W'(255);
    in_range = in_range && (item.col < 8'(cfg.cols) || cfg.cols > rhf_pkg::DIM_W'(255));
    need = cfg.need > 4'd8 ? 4'd8 : cfg.need;
    rd_en = 1'b0;
    rd_addr = {row_r, col_r};
    if (state_r == S_IDLE && start) begin
      rd_en = 1'b1;
      rd_addr = {item.row, item.col};
    end else if (state_r == S_STEP && d_r != '0 && !off_edge) begin
      rd_en = 1'b1;
      rd_addr = {pr[rhf_pkg::ROW_W-1:0], pc[rhf_pkg::COL_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy && item.operation == rhf_pkg::OP_LOAD && in_range)
      mem[{item.row, item.col}] <= {item.height_valid, item.height};
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  assign prod = $signed({1'b0, hit_w_r}) * hit_h_r;
  assign mag = num_r[rhf_pkg::NUM_W-1] ? rhf_pkg::NUM_W'(-num_r) : rhf_pkg::NUM_W'(num_r);
  assign div_start = state_r == S_ACC && d_r != '0 && div_start_chk();
  assign in_div = state_r == S_DIV && !div_done;
  assign div_next_ok = state_r == S_DIV || state_r == S_DONE;

  rhf_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(mag + rhf_pkg::NUM_W'(den_r >> 1)), .den(den_r),
    .done(div_done), .quo(div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_strobe <= 1'b0;
      busy       <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      unique case (state_r)
        S_IDLE: if (start) begin
          row_r <= item.row;
          col_r <= item.col;
          if (item.operation == rhf_pkg::OP_QUERY) begin
            if (in_range) begin
              busy    <= 1'b1;
              state_r <= S_CENTER;
            end else begin
              out_item   <= '0;
              out_strobe <= 1'b1;
            end
          end
        end
        S_CENTER: begin
          if (rdata_r[rhf_pkg::HGT_W]) begin
            out_item   <= '{out_height: rdata_r[rhf_pkg::HGT_W-1:0], out_valid: 1'b1,
                            was_filled: 1'b0};
            out_strobe <= 1'b1;
            busy       <= 1'b0;
            state_r    <= S_IDLE;
          end else begin
            dir_r <= 3'd0; d_r <= rhf_pkg::REACH_W'(1);
            miss_r <= '0; num_r <= '0; den_r <= '0;
            hit_w_r <= '0; hit_h_r <= '0;
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          if (d_r == '0 || d_r > reach) begin
            miss_r <= miss_r + 4'd1; hit_w_r <= '0; d_r <= '0; state_r <= S_ACC;
          end else if (off_edge) begin
            hit_w_r <= '0; d_r <= '0; state_r <= S_ACC;
          end else state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (rdata_r[rhf_pkg::HGT_W]) begin
            hit_w_r <= rhf_pkg::weight(diag, d_r);
            hit_h_r <= rdata_r[rhf_pkg::HGT_W-1:0];
            d_r <= '0; state_r <= S_ACC;
          end else begin
            d_r <= d_r + 1'b1; state_r <= S_STEP;
          end
        end
        S_ACC: begin
          if (d_r == '0) begin
            num_r <= num_r + rhf_pkg::NUM_W'(prod);
            den_r <= den_r + rhf_pkg::DEN_W'(hit_w_r);
            hit_w_r <= '0;
            if (dir_r == 3'd7) d_r <= rhf_pkg::REACH_W'(1);
            else begin
              dir_r <= dir_r + 3'd1; d_r <= rhf_pkg::REACH_W'(1); state_r <= S_STEP;
            end
          end else if (div_start) begin
            neg_r <= num_r[rhf_pkg::NUM_W-1]; state_r <= S_DIV;
          end else begin
            out_item <= '0; out_strobe <= 1'b1; busy <= 1'b0; state_r <= S_IDLE;
          end
        end
        S_DIV: if (div_done) state_r <= S_DONE;
        default: begin
          out_item <= '{out_height: neg_r ? -rhf_pkg::HGT_W'(div_quo) :
                        rhf_pkg::HGT_W'(div_quo), out_valid: 1'b1, was_filled: 1'b1};
          out_strobe <= 1'b1; busy <= 1'b0; state_r <= S_IDLE;
        end
      endcase
    end
  end

  // divider launches in the cycle after the last direction is summed, if a fill is allowed
  `RHF_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_strobe, !busy, "strobe while busy")
  `RHF_ASSERT_NEXT(a_div_run, clk, rst_n, in_div, div_next_ok, "divider left")
  `RHF_ASSERT_IMP(a_miss_bound, clk, rst_n, state_r == S_ACC, miss_r <= 4'd8, "miss overflow")
endmodule
`default_nettype wire

/* test/raster_hole_fill_idw_unit_tb.sv */
// Testbench for the raster hole-fill block: loads cells, queries holes, checks fills.
`timescale 1ns / 100ps
`default_nettype none
module raster_hole_fill_idw_unit_tb;
  localparam int SIDE = 12;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  class fill_scoreboard;
    rhf_pkg::out_item_t pending[$];
    logic [rhf_pkg::CELL_W-1:0] cells[int];
    logic [3:0] need;
    logic [3:0] reach_c, reach_d;
    logic [8:0] rows, cols;
    int errors;

    function void reset_state();
      cells.delete();
      pending.delete();
      need = 4'd8; reach_c = 4'd3; reach_d = 4'd2; rows = 9'd256; cols = 9'd256;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        rhf_pkg::REG_NEED: need = v[3:0];
        rhf_pkg::REG_CRCH: reach_c = v[3:0];
        rhf_pkg::REG_DRCH: reach_d = v[3:0];
        rhf_pkg::REG_ROWS: rows = v[8:0];
        rhf_pkg::REG_COLS: cols = v[8:0];
        default: ;
      endcase
    endfunction

    function logic [rhf_pkg::CELL_W-1:0] peek(int r, int c);
      int a;
      a = r * rhf_pkg::MAX_COLS + c;
      return cells.exists(a) ? cells[a] : '0;
    endfunction

    function void note_input(rhf_pkg::in_item_t it);
      int nr, nc, rc, rd, nmax, misses, r, c, rch, w;
      longint num, den, q;
      logic [rhf_pkg::CELL_W-1:0] e;
      rhf_pkg::out_item_t res;
      bit diag, missed, in_win;
      int dr[8] = '{0, 0, 1, -1, 1, 1, -1, -1};
      int dc[8] = '{1, -1, 0, 0, 1, -1, 1, -1};
      nr = rows == 0 ? 1 : (rows > rhf_pkg::MAX_ROWS ? rhf_pkg::MAX_ROWS : rows);
      nc = cols == 0 ? 1 : (cols > rhf_pkg::MAX_COLS ? rhf_pkg::MAX_COLS : cols);
      nmax = 8 - (need > 8 ? 8 : need);
      rc = reach_c > rhf_pkg::MAX_REACH ? rhf_pkg::MAX_REACH : reach_c;
      rd = reach_d > rhf_pkg::MAX_REACH ? rhf_pkg::MAX_REACH : reach_d;
      in_win = it.row < nr && it.col < nc;
      if (it.operation == rhf_pkg::OP_LOAD) begin
        if (in_win) cells[it.row * rhf_pkg::MAX_COLS + it.col] = {it.height_valid, it.height};
        return;
      end
      res = '0;
      if (in_win) begin
        e = peek(it.row, it.col);
        if (e[rhf_pkg::HGT_W]) begin
          res.out_height = e[rhf_pkg::HGT_W-1:0];
          res.out_valid = 1'b1;
        end else begin
          misses = 0; num = 0; den = 0;
          for (int i = 0; i < 8; i++) begin
            diag = i >= 4;
            rch = diag ? rd : rc;
            missed = 1;
            for (int d = 1; d <= rch; d++) begin
              r = it.row + d * dr[i];
              c = it.col + d * dc[i];
              if (r < 0 || c < 0 || r >= nr || c >= nc) begin
                missed = 0;
                break;
              end
              e = peek(r, c);
              if (!e[rhf_pkg::HGT_W]) continue;
              w = ((diag ? 46341 : 65536) + d / 2) / d;
              num += longint'(w) * longint'($signed(e[rhf_pkg::HGT_W-1:0]));
              den += w;
              missed = 0;
              break;
            end
            if (missed) misses++;
          end
          if (misses <= nmax && den != 0) begin
            q = num >= 0 ? (num + den / 2) / den : -((-num + den / 2) / den);
            res.out_height = q[rhf_pkg::HGT_W-1:0];
            res.out_valid = 1'b1;
            res.was_filled = 1'b1;
          end
        end
      end
      pending.push_back(res);
    endfunction

    task report(string what, rhf_pkg::out_item_t got, rhf_pkg::out_item_t want);
      errors++;
      if (errors <= 40) $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    task check_result(rhf_pkg::out_item_t got);
      rhf_pkg::out_item_t want;
      if (pending.size() == 0) begin
        report("unexpected result", got, '0);
        return;
      end
      want = pending.pop_front();
      if (got.out_height !== want.out_height) report("out_height", got, want);
      if (got.out_valid !== want.out_valid) report("out_valid", got, want);
      if (got.was_filled !== want.was_filled) report("was_filled", got, want);
    endtask
  endclass

  logic clk = 0, rst_n = 0, start = 0, busy, out_strobe, psel = 0, penable = 0, pwrite = 0;
  logic pready;
  logic [rhf_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  rhf_pkg::in_item_t in_item = '0;
  rhf_pkg::out_item_t out_item;
  fill_scoreboard sb = new();
  int cur_rows = 256, cur_cols = 256;

  raster_hole_fill_idw_unit u_top (
    .clk, .rst_n, .start, .busy, .in_item, .out_strobe, .out_item,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_item);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= rhf_pkg::PADDR_W'(idx * 4); pwdata <= v;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, v);
    if (idx == rhf_pkg::REG_ROWS) cur_rows = int'(v[8:0]);
    if (idx == rhf_pkg::REG_COLS) cur_cols = int'(v[8:0]);
  endtask

  task automatic send(rhf_pkg::in_item_t it);
    repeat ($urandom_range(15)) @(posedge clk);
    @(posedge clk);
    start <= 1; in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
    start <= 0;
  endtask

  task automatic wait_idle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (350) @(posedge clk);
  endtask

  function automatic rhf_pkg::in_item_t mk(logic op, int r, int c, int h, logic hv);
    rhf_pkg::in_item_t it;
    it.operation = op; it.row = r[7:0]; it.col = c[7:0];
    it.height = h[rhf_pkg::HGT_W-1:0]; it.height_valid = hv;
    return it;
  endfunction

  // fill the used window so no query ever reads an unwritten cell
  task automatic paint(int nr, int nc, int hole_pct);
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        send(mk(rhf_pkg::OP_LOAD, r, c, $urandom, $urandom_range(99) >= hole_pct));
  endtask

  // most queries stay within qr rows and qc columns of the painted window; an occasional one is pushed out of range
  task automatic random_phase(int n, int qr = 256, int qc = 256);
    rhf_pkg::in_item_t it;
    int nr, nc, mr, mc;
    nr = cur_rows == 0 ? 1 : (cur_rows > 256 ? 256 : cur_rows);
    nc = cur_cols == 0 ? 1 : (cur_cols > 256 ? 256 : cur_cols);
    mr = qr < nr ? qr : nr;
    mc = qc < nc ? qc : nc;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) < 6) begin
        it = mk(rhf_pkg::OP_QUERY, $urandom_range(mr - 1), $urandom_range(mc - 1),
                $urandom, 1'($urandom));
        if ($urandom_range(19) == 0) begin
          it.row = 8'($urandom);
          it.col = 8'($urandom);
          if (it.row < nr && it.col < nc) begin
            if (nr < 256) it.row = 8'(nr);
            else it.col = 8'(nc);
          end
        end
      end else begin
        it = mk(rhf_pkg::OP_LOAD, $urandom_range(nr - 1), $urandom_range(nc - 1), $urandom,
                $urandom_range(2) != 0);
        if ($urandom_range(9) == 0) it.row = 8'($urandom);
      end
      send(it);
      if (k == n / 2) wait_idle();
    end
    wait_idle();
  endtask

  initial begin
    sb.reset_state();
    repeat (4) @(posedge clk);
    rst_n <= 1;
    write_reg(rhf_pkg::REG_ROWS, SIDE);
    write_reg(rhf_pkg::REG_COLS, SIDE);
    paint(SIDE, SIDE, 40);
    send(mk(rhf_pkg::OP_LOAD, 0, 0, 20'h7FFFF, 1));
    send(mk(rhf_pkg::OP_LOAD, 0, 2, -524288, 1));
    send(mk(rhf_pkg::OP_LOAD, 0, 1, 0, 0));
    send(mk(rhf_pkg::OP_QUERY, 0, 0, 0, 0));
    send(mk(rhf_pkg::OP_QUERY, 0, 1, 0, 0));
    send(mk(rhf_pkg::OP_QUERY, 5, 5, 0, 0));
    send(mk(rhf_pkg::OP_QUERY, 255, 255, 0, 0));
    send(mk(rhf_pkg::OP_LOAD, 200, 3, 5, 1));
    write_reg(rhf_pkg::REG_NEED, 0);
    send(mk(rhf_pkg::OP_QUERY, 0, 1, 0, 0));
    send(mk(rhf_pkg::OP_QUERY, 6, 6, 0, 0));
    wait_idle();
    write_reg(rhf_pkg::REG_CRCH, 0);
    write_reg(rhf_pkg::REG_DRCH, 0);
    send(mk(rhf_pkg::OP_QUERY, 0, 1, 0, 0));
    wait_idle();
    write_reg(rhf_pkg::REG_CRCH, 15);
    write_reg(rhf_pkg::REG_DRCH, 15);
    send(mk(rhf_pkg::OP_QUERY, 0, 1, 0, 0));
    random_phase(40);
    write_reg(rhf_pkg::REG_NEED, 15);
    write_reg(rhf_pkg::REG_ROWS, 1);
    write_reg(rhf_pkg::REG_COLS, 256);
    paint(1, 48, 50);
    random_phase(50, 1, 32);
    write_reg(rhf_pkg::REG_ROWS, 511);
    write_reg(rhf_pkg::REG_COLS, 0);
    paint(48, 1, 50);
    write_reg(rhf_pkg::REG_NEED, 4);
    random_phase(50, 32, 1);
    write_reg(rhf_pkg::REG_ROWS, 9);
    write_reg(rhf_pkg::REG_COLS, 7);
    write_reg(rhf_pkg::REG_NEED, 8);
    write_reg(rhf_pkg::REG_CRCH, 3);
    write_reg(rhf_pkg::REG_DRCH, 2);
    paint(9, 7, 30);
    random_phase(50);
    write_reg(rhf_pkg::REG_NEED, 6);
    write_reg(rhf_pkg::REG_CRCH, 2);
    write_reg(rhf_pkg::REG_DRCH, 1);
    write_reg(REG_UNUSED, 32'hFFFFFFFF);
    random_phase(50);
    if (sb.errors == 0) begin
      $display("raster_hole_fill_idw_unit test passed");
    end else begin
      $display("raster_hole_fill_idw_unit test failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("raster_hole_fill_idw_unit test failed");
    $finish;
  end
endmodule
